[hdl/fsra_pkg.sv]
package fsra_pkg;

  localparam logic [1:0] OP_INVALID = 2'd0;
  localparam logic [1:0] OP_FIRST   = 2'd1;
  localparam logic [1:0] OP_BEST    = 2'd2;
  localparam logic [1:0] OP_WORST   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef struct packed {
    logic    init_wr;
    logic    load;
    logic    scan_rd;
    logic    split_begin;
    logic    shift_rd;
    logic    wr_pick;
    logic    wr_rest;
    logic    finish;
    status_e res;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic scan_issued;
    logic eval_pend;
    logic found;
    logic exact;
    logic full;
    logic shift_issued;
    logic mv_pend;
  } sts_t;

endpackage

[hdl/fit_strategy_region_allocator.sv]
// Channel   Direction  Handshake            Word
// request   in         start && !busy       op_i, request_size_i
// result    out        done_o (one cycle)   status_o, alloc_start_o
// config    in         total_size_we_i      total_size_i
//
// A request makes one read-port pass over the table RAM to pick a region and,
// on a split, a second pass to move entries up by one; a split can meet at
// most MAX_REGIONS - 1 table regions (63 by default). Invalid requests are
// rejected in the check state, before any table pass.
// After reset or a total_size write, the init state writes the initial region.
// Results cannot be stalled; busy stays high until the result strobe.
module fit_strategy_region_allocator #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        total_size_we_i,
  input  logic [15:0] total_size_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [15:0] request_size_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] alloc_start_o
);

  fsra_pkg::cmd_t cmd;
  fsra_pkg::sts_t sts;

  fsra_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .total_size_we_i(total_size_we_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .done_o         (done_o)
  );

  fsra_dp #(
    .MAX_REGIONS(MAX_REGIONS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_size_we_i(total_size_we_i),
    .total_size_i   (total_size_i),
    .op_i           (op_i),
    .request_size_i (request_size_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status_o),
    .alloc_start_o  (alloc_start_o)
  );

endmodule

[hdl/fsra_table_ram.sv]
module fsra_table_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/fsra_dp.sv]
module fsra_dp #(
  parameter int MAX_REGIONS = 64,
  parameter int ADDR_BITS   = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    total_size_we_i,
  input  logic [15:0]             total_size_i,
  input  logic [1:0]              op_i,
  input  logic [15:0]             request_size_i,
  input  fsra_pkg::cmd_t          cmd_i,
  output fsra_pkg::sts_t          sts_o,
  output logic [1:0]              status_o,
  output logic [15:0]             alloc_start_o
);

  localparam int AB   = ADDR_BITS;
  localparam int IW   = $clog2(MAX_REGIONS);
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int CMPW = (AB > 16) ? AB : 16;
  localparam logic [CMPW-1:0] RST_TOTAL = CMPW'(16'hFFFF);

  typedef struct packed {
    logic          used;
    logic [AB-1:0] size;
    logic [AB-1:0] start;
  } entry_t;

  localparam int EW = $bits(entry_t);

  logic [AB-1:0]   total_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic [IW-1:0]   sidx_q;
  logic [IW-1:0]   rd_idx_q;
  logic            eval_q;
  logic            mv_q;
  logic            found_q;
  logic [1:0]      op_q;
  logic [15:0]     req_q;
  logic [IW-1:0]   pick_idx_q;
  logic [AB-1:0]   pick_size_q;
  logic [AB-1:0]   pick_start_q;
  logic [1:0]      status_q;
  logic [15:0]     alloc_start_q;

  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;
  logic [IW-1:0]   raddr;
  logic [EW-1:0]   rdata;
  entry_t          rd_e;
  logic [CMPW-1:0] req_ext;
  logic [AB-1:0]   req_ab;
  logic [CMPW-1:0] total_ext;
  logic [CMPW-1:0] start_ext;
  logic [CW-1:0]   count_m1;
  logic            fits;
  logic            take;

  assign req_ext   = CMPW'(req_q);
  assign req_ab    = req_ext[AB-1:0];
  assign total_ext = CMPW'(total_size_i);
  assign start_ext = CMPW'(pick_start_q);
  assign count_m1  = count_q - CW'(1);
  assign rd_e      = entry_t'(rdata);

  assign fits = !rd_e.used && (CMPW'(rd_e.size) >= req_ext);
  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_q) begin
        take = 1'b1;
      end else if (op_q == fsra_pkg::OP_BEST && rd_e.size < pick_size_q) begin
        take = 1'b1;
      end else if (op_q == fsra_pkg::OP_WORST && rd_e.size > pick_size_q) begin
        take = 1'b1;
      end
    end
  end

  assign raddr = cmd_i.shift_rd ? sidx_q : idx_q[IW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.init_wr) begin
      we         = 1'b1;
      wdata.size = total_q;
    end else if (mv_q) begin
      we    = 1'b1;
      waddr = rd_idx_q + IW'(1);
      wdata = rd_e;
    end else if (cmd_i.wr_pick) begin
      we          = 1'b1;
      waddr       = pick_idx_q;
      wdata.used  = 1'b1;
      wdata.size  = req_ab;
      wdata.start = pick_start_q;
    end else if (cmd_i.wr_rest) begin
      we          = 1'b1;
      waddr       = pick_idx_q + IW'(1);
      wdata.size  = pick_size_q - req_ab;
      wdata.start = pick_start_q + req_ab;
    end
  end

  fsra_table_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_REGIONS),
    .AW   (IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= RST_TOTAL[AB-1:0];
      count_q <= CW'(1);
      idx_q   <= '0;
      sidx_q  <= '0;
      eval_q  <= 1'b0;
      mv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.scan_rd;
      mv_q   <= cmd_i.shift_rd;
      if (total_size_we_i) begin
        total_q <= total_ext[AB-1:0];
      end
      if (cmd_i.init_wr) begin
        count_q <= CW'(1);
      end else if (cmd_i.wr_rest) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + CW'(1);
      end
      if (eval_q && take) begin
        found_q <= 1'b1;
      end
      if (cmd_i.split_begin) begin
        sidx_q <= count_m1[IW-1:0];
      end else if (cmd_i.shift_rd) begin
        sidx_q <= sidx_q - IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= raddr;
    if (cmd_i.load) begin
      op_q  <= op_i;
      req_q <= request_size_i;
    end
    if (eval_q && take) begin
      pick_idx_q   <= rd_idx_q;
      pick_size_q  <= rd_e.size;
      pick_start_q <= rd_e.start;
    end
    if (cmd_i.finish) begin
      status_q      <= cmd_i.res;
      alloc_start_q <= (cmd_i.res == fsra_pkg::ST_OK) ? start_ext[15:0] : 16'd0;
    end
  end

  assign sts_o.invalid      = (op_q == fsra_pkg::OP_INVALID) || (req_q == 16'd0);
  assign sts_o.scan_issued  = (idx_q == count_q);
  assign sts_o.eval_pend    = eval_q;
  assign sts_o.found        = found_q;
  assign sts_o.exact        = (CMPW'(pick_size_q) == req_ext);
  assign sts_o.full         = (count_q == CW'(MAX_REGIONS));
  assign sts_o.shift_issued = (sidx_q == pick_idx_q);
  assign sts_o.mv_pend      = mv_q;

  assign status_o      = status_q;
  assign alloc_start_o = alloc_start_q;

endmodule

[hdl/fsra_ctrl.sv]
module fsra_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           total_size_we_i,
  input  fsra_pkg::sts_t sts_i,
  output fsra_pkg::cmd_t cmd_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_WREST
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.res = fsra_pkg::ST_OK;
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.invalid) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = fsra_pkg::ST_INVALID;
          state_d      = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = !sts_i.scan_issued;
        if (sts_i.scan_issued && !sts_i.eval_pend) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts_i.found) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = fsra_pkg::ST_NOFIT;
          state_d      = S_IDLE;
        end else if (sts_i.exact) begin
          cmd_o.wr_pick = 1'b1;
          cmd_o.finish  = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.full) begin
          cmd_o.finish = 1'b1;
          cmd_o.res    = fsra_pkg::ST_FULL;
          state_d      = S_IDLE;
        end else begin
          cmd_o.split_begin = 1'b1;
          state_d           = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_rd = !sts_i.shift_issued;
        if (sts_i.shift_issued && !sts_i.mv_pend) begin
          cmd_o.wr_pick = 1'b1;
          state_d       = S_WREST;
        end
      end
      S_WREST: begin
        cmd_o.wr_rest = 1'b1;
        cmd_o.finish  = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
    if (total_size_we_i) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

[hdl/fsra_checker.sv]
module fsra_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op_i,
  input logic [15:0] request_size_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [15:0] alloc_start_o
);

  a_fail_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != fsra_pkg::ST_OK) |-> alloc_start_o == 16'd0)
    else $error("failed request with nonzero start");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy low after accepted word");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without work in flight");

  a_invalid_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == fsra_pkg::OP_INVALID || request_size_i == 16'd0))
    |=> ##1 (done_o && status_o == fsra_pkg::ST_INVALID))
    else $error("invalid request not rejected");

endmodule

bind fit_strategy_region_allocator fsra_checker u_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  localparam int NREG      = 64;
  localparam int LIMIT     = 1_000_000;
  localparam int PHASES    = 10;
  localparam int PHASE_LEN = 95;

  typedef struct packed {
    fsra_pkg::status_e st;
    logic [15:0]       addr;
  } grant_t;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        op;
    logic [15:0]       val;
    logic              typed;
    fsra_pkg::status_e st;
    logic [15:0]       addr;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        total_size_we_i;
  logic [15:0] total_size_i;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [15:0] request_size_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] alloc_start_o;

  fit_strategy_region_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .total_size_we_i(total_size_we_i),
    .total_size_i   (total_size_i),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .request_size_i (request_size_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .alloc_start_o  (alloc_start_o)
  );

  // shadow region table
  logic [15:0] rg_start [NREG];
  logic [15:0] rg_size  [NREG];
  bit          rg_used  [NREG];
  int          rg_cnt;

  grant_t grant_q[$];
  int     idle_pct;
  int     err_cnt;
  int     cyc = 0;
  int     n_ok, n_nofit, n_full, n_inv, n_cfg;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    grant_t exp_w;
    if (rst_ni && done_o) begin
      case (status_o)
        fsra_pkg::ST_OK:    n_ok++;
        fsra_pkg::ST_NOFIT: n_nofit++;
        fsra_pkg::ST_FULL:  n_full++;
        default:            n_inv++;
      endcase
      if (grant_q.size() == 0) begin
        $error("result word with nothing expected: status %0d start %0d",
               status_o, alloc_start_o);
        err_cnt++;
      end else begin
        exp_w = grant_q.pop_front();
        if (status_o !== exp_w.st) begin
          $error("status: expected %0d, got %0d", exp_w.st, status_o);
          err_cnt++;
        end
        if (alloc_start_o !== exp_w.addr) begin
          $error("alloc_start: expected %0d, got %0d", exp_w.addr, alloc_start_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic table_init(input logic [15:0] total);
    for (int i = 0; i < NREG; i++) begin
      rg_start[i] = '0;
      rg_size[i]  = '0;
      rg_used[i]  = 1'b0;
    end
    rg_size[0] = total;
    rg_cnt     = 1;
  endtask

  task automatic alloc_predict(input logic [1:0] op, input logic [15:0] sz,
                               output fsra_pkg::status_e st, output logic [15:0] addr);
    bit found;
    int pick;
    found = 1'b0;
    pick  = 0;
    st    = fsra_pkg::ST_OK;
    addr  = '0;
    if (op == fsra_pkg::OP_INVALID || sz == 0) begin
      st = fsra_pkg::ST_INVALID;
      return;
    end
    for (int i = 0; i < rg_cnt; i++) begin
      if (!rg_used[i] && rg_size[i] >= sz && !(found && op == fsra_pkg::OP_FIRST)) begin
        if (!found) begin
          found = 1'b1;
          pick  = i;
        end else if (op == fsra_pkg::OP_BEST && rg_size[i] < rg_size[pick]) begin
          pick = i;
        end else if (op == fsra_pkg::OP_WORST && rg_size[i] > rg_size[pick]) begin
          pick = i;
        end
      end
    end
    if (!found) begin
      st = fsra_pkg::ST_NOFIT;
      return;
    end
    if (rg_size[pick] != sz) begin
      if (rg_cnt >= NREG) begin
        st = fsra_pkg::ST_FULL;
        return;
      end
      for (int j = rg_cnt; j > pick + 1; j--) begin
        rg_start[j] = rg_start[j-1];
        rg_size[j]  = rg_size[j-1];
        rg_used[j]  = rg_used[j-1];
      end
      rg_start[pick+1] = rg_start[pick] + sz;
      rg_size[pick+1]  = rg_size[pick] - sz;
      rg_used[pick+1]  = 1'b0;
      rg_size[pick]    = sz;
      rg_cnt++;
    end
    rg_used[pick] = 1'b1;
    addr = rg_start[pick];
  endtask

  function automatic logic [15:0] largest_free();
    logic [15:0] m;
    m = '0;
    for (int i = 0; i < rg_cnt; i++)
      if (!rg_used[i] && rg_size[i] > m) m = rg_size[i];
    return m;
  endfunction

  // start may still be high from the previous word; it is only lowered when idling or before a total_size write
  task automatic send_word(input logic [1:0] op, input logic [15:0] sz,
                           input bit typed, input grant_t typed_w);
    fsra_pkg::status_e st;
    logic [15:0]       addr;
    grant_t            w;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    op_i           <= op;
    request_size_i <= sz;
    do @(posedge clk_i); while (busy);
    alloc_predict(op, sz, st, addr);
    w.st   = st;
    w.addr = addr;
    grant_q.insert(grant_q.size(), typed ? typed_w : w);
  endtask

  task automatic set_total(input logic [15:0] v);
    start <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    total_size_we_i <= 1'b1;
    total_size_i    <= v;
    @(posedge clk_i);
    total_size_we_i <= 1'b0;
    table_init(v);
    n_cfg++;
  endtask

  dir_row_t dir_tab [25];
  logic [15:0] phase_total [PHASES];

  initial begin
    grant_t      tw;
    logic [1:0]  op;
    logic [15:0] sz;
    logic [15:0] room;
    int          sel;
    int          idle_set [3];

    rst_ni          <= 1'b0;
    total_size_we_i <= 1'b0;
    total_size_i    <= '0;
    start           <= 1'b0;
    op_i            <= fsra_pkg::OP_INVALID;
    request_size_i  <= '0;
    err_cnt = 0;
    n_ok = 0; n_nofit = 0; n_full = 0; n_inv = 0; n_cfg = 0;
    idle_pct = 0;
    idle_set = '{0, 57, 25};
    table_init(16'hFFFF);

    dir_tab = '{
      '{1'b0, fsra_pkg::OP_INVALID, 16'd0,    1'b1, fsra_pkg::ST_INVALID, 16'd0},
      '{1'b0, fsra_pkg::OP_INVALID, 16'hFFFF, 1'b1, fsra_pkg::ST_INVALID, 16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'd0,    1'b1, fsra_pkg::ST_INVALID, 16'd0},
      '{1'b0, fsra_pkg::OP_WORST,   16'hFFFF, 1'b1, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_BEST,    16'd1,    1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b1, fsra_pkg::OP_INVALID, 16'd0,    1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'd1,    1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b0, fsra_pkg::OP_WORST,   16'hFFFF, 1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b1, fsra_pkg::OP_INVALID, 16'd1,    1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_BEST,    16'd2,    1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b0, fsra_pkg::OP_BEST,    16'd1,    1'b1, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'd1,    1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b1, fsra_pkg::OP_INVALID, 16'd100,  1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'd10,   1'b1, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_BEST,    16'd20,   1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_WORST,   16'd30,   1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'd41,   1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b0, fsra_pkg::OP_WORST,   16'd40,   1'b1, fsra_pkg::ST_OK,      16'd60},
      '{1'b0, fsra_pkg::OP_BEST,    16'hFFFF, 1'b1, fsra_pkg::ST_NOFIT,   16'd0},
      '{1'b1, fsra_pkg::OP_INVALID, 16'hFFFF, 1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_FIRST,   16'h8000, 1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_BEST,    16'h7FFF, 1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_INVALID, 16'h5555, 1'b1, fsra_pkg::ST_INVALID, 16'd0},
      '{1'b1, fsra_pkg::OP_INVALID, 16'hAAAA, 1'b0, fsra_pkg::ST_OK,      16'd0},
      '{1'b0, fsra_pkg::OP_WORST,   16'h5555, 1'b0, fsra_pkg::ST_OK,      16'd0}
    };

    phase_total = '{16'hFFFF, 16'd64, 16'd0, 16'd1, 16'd63,
                    16'($urandom), 16'd200, 16'hFFFF, 16'($urandom), 16'h5555};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        set_total(dir_tab[r].val);
      end else begin
        tw.st   = dir_tab[r].st;
        tw.addr = dir_tab[r].addr;
        send_word(dir_tab[r].op, dir_tab[r].val, dir_tab[r].typed, tw);
      end
    end

    tw = '0;
    for (int p = 0; p < PHASES; p++) begin
      set_total(phase_total[p]);
      idle_pct = idle_set[p % 3];
      for (int k = 0; k < PHASE_LEN; k++) begin
        room = largest_free();
        sel  = $urandom_range(99);
        op   = 2'($urandom_range(3, 1));
        if (sel < 6) begin
          op = fsra_pkg::OP_INVALID;
          sz = 16'($urandom);
        end else if (sel < 10) begin
          sz = '0;
        end else if (sel < 15) begin
          op = 2'($urandom);
          sz = 16'($urandom);
        end else if (sel < 27 && room != 0) begin
          sz = room;
        end else if (sel < 65) begin
          sz = 16'($urandom_range(16, 1));
        end else begin
          sz = 16'($urandom_range((room >> 3) != 0 ? (room >> 3) : 1, 1));
        end
        send_word(op, sz, 1'b0, tw);
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    $display("covered %0d result words: %0d granted, %0d no fit, %0d table full, %0d rejected",
             n_ok + n_nofit + n_full + n_inv, n_ok, n_nofit, n_full, n_inv);
    $display("across %0d total_size settings with sender idling of 0, 57 and 25 percent",
             n_cfg);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/fsra_pkg.sv
hdl/fsra_table_ram.sv
hdl/fsra_dp.sv
hdl/fsra_ctrl.sv
hdl/fit_strategy_region_allocator.sv
hdl/fsra_checker.sv
tb/tb_top.sv
